// ===== hw/rtl/dhmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhmt_pkg
// Shared types and codes for the deadline health monitor table.
// ----------------------------------------------------------------------------
`default_nettype none

package dhmt_pkg;

  // Request type codes
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_TOUCH    = 2'd1;
  localparam logic [1:0] REQ_POLL     = 2'd2;
  localparam logic [1:0] REQ_SPARE    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_EXPIRY        = 2'd1;
  localparam logic [1:0] ST_FULL          = 2'd2;
  localparam logic [1:0] ST_ZERO_DEADLINE = 2'd3;

  // Event kind codes
  localparam logic EV_EXPIRY = 1'b0;
  localparam logic EV_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] task_key;
    logic [31:0] limit_ms;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic        event_kind;
    logic [31:0] report_key;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  // One table entry as read from the store
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] deadline;
    logic [31:0] touch_time;
    logic        expired;
  } entry_t;

  // Per-field write enables into the table
  typedef struct packed {
    logic key;
    logic deadline;
    logic touch_time;
    logic expired;
  } tbl_wr_t;

  // Result of evaluating one entry against the current request
  typedef struct packed {
    logic key_hit;
    logic overdue;
  } eval_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STATUS
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dhmt_table.sv =====
// ----------------------------------------------------------------------------
// dhmt_table
// Entry store: one write port with per-field enables, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dhmt_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int IW          = 4
) (
  input  wire                  clk,
  input  wire dhmt_pkg::tbl_wr_t wr_en,
  input  wire [IW-1:0]         wr_addr,
  input  wire dhmt_pkg::entry_t  wr_data,
  input  wire [IW-1:0]         rd_addr,
  output dhmt_pkg::entry_t       rd_data
);
  import dhmt_pkg::*;

  logic [31:0] key_mem      [TABLE_DEPTH];
  logic [31:0] deadline_mem [TABLE_DEPTH];
  logic [31:0] touch_mem    [TABLE_DEPTH];
  logic        expired_mem  [TABLE_DEPTH];

  entry_t rd_data_r;

  // Write the enabled fields of one entry
  always_ff @(posedge clk) begin
    if (wr_en.key)        key_mem[wr_addr]      <= wr_data.key;
    if (wr_en.deadline)   deadline_mem[wr_addr] <= wr_data.deadline;
    if (wr_en.touch_time) touch_mem[wr_addr]    <= wr_data.touch_time;
    if (wr_en.expired)    expired_mem[wr_addr]  <= wr_data.expired;
  end

  // Read one entry per cycle
  always_ff @(posedge clk) begin
    rd_data_r.key        <= key_mem[rd_addr];
    rd_data_r.deadline   <= deadline_mem[rd_addr];
    rd_data_r.touch_time <= touch_mem[rd_addr];
    rd_data_r.expired    <= expired_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dhmt_eval.sv =====
// ----------------------------------------------------------------------------
// dhmt_eval
// Shared compare unit: key match and wrapping-age deadline check of one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dhmt_eval (
  input  wire [31:0]           req_key,
  input  wire [31:0]           now_ms,
  input  wire dhmt_pkg::entry_t  entry,
  output dhmt_pkg::eval_t        result
);
  import dhmt_pkg::*;

  logic [31:0] age;

  // Age wraps modulo 2^32; overdue only when strictly past the deadline
  always_comb begin
    age            = now_ms - entry.touch_time;
    result.key_hit = (entry.key == req_key);
    result.overdue = !entry.expired && (age > entry.deadline);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/deadline_health_monitor_table_core.sv =====
// ----------------------------------------------------------------------------
// deadline_health_monitor_table_core
// Task watchdog table: register, touch and poll requests over a walked store.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_ready  | in_word_t (req, key, deadline, now)
//   out_    | output    | out_valid/out_ready| out_word_t (kind, key, status, last)
//
// A request is accepted, then walks the table entry by entry, as the table has
// a single read port (at least one entry, at most TABLE_DEPTH), then emits the
// status word. Zero-deadline register requests and unused requests skip the
// walk. A stalled result port holds a poll walk at the current overdue entry
// and holds back the status word. Reset empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_health_monitor_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire dhmt_pkg::in_word_t in_word,
  output logic                  out_valid,
  input  wire                   out_ready,
  output dhmt_pkg::out_word_t     out_word
);
  import dhmt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t      state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [1:0]  req_r;
  logic [31:0] key_r, deadline_r, now_r;

  logic      out_valid_r;
  out_word_t out_word_r;
  logic      out_free;
  logic      load_rpt, load_sts;

  tbl_wr_t       wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  eval_t         ev;
  logic          have, is_last;

  dhmt_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IW         (IW)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(idx_nxt),
    .rd_data(rd_data)
  );

  dhmt_eval u_eval (
    .req_key(key_r),
    .now_ms (now_r),
    .entry  (rd_data),
    .result (ev)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign have      = (count_r != '0);
  assign is_last   = !have || ((CW'(idx_r) + CW'(1)) == count_r);

  // Sequence the walk and decide writes and emitted words
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    st_nxt     = st_r;
    wr_en      = '0;
    wr_addr    = idx_r;
    wr_data.key        = key_r;
    wr_data.deadline   = deadline_r;
    wr_data.touch_time = now_r;
    wr_data.expired    = 1'b0;
    load_rpt   = 1'b0;
    load_sts   = 1'b0;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          st_nxt = ST_OK;
          if (in_word.req_type == REQ_REGISTER && in_word.limit_ms == '0) begin
            st_nxt    = ST_ZERO_DEADLINE;
            state_nxt = S_STATUS;
          end else if (in_word.req_type inside {REQ_REGISTER, REQ_TOUCH, REQ_POLL}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_SCAN: begin
        case (req_r)
          REQ_REGISTER: begin
            if (have && ev.key_hit) begin
              wr_en.deadline = 1'b1;
              state_nxt      = S_STATUS;
            end else if (is_last) begin
              if (count_r != CW'(TABLE_DEPTH)) begin
                wr_en     = '1;
                wr_addr   = count_r[IW-1:0];
                count_nxt = count_r + CW'(1);
              end else begin
                st_nxt = ST_FULL;
              end
              state_nxt = S_STATUS;
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
          end
          REQ_TOUCH: begin
            if (have && ev.key_hit) begin
              wr_en.touch_time = 1'b1;
              wr_en.expired    = 1'b1;
              state_nxt        = S_STATUS;
            end else if (is_last) begin
              state_nxt = S_STATUS;
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
          end
          REQ_POLL: begin
            if (have && ev.overdue) begin
              // Hold the walk on this entry until the result port is free
              if (out_free) begin
                load_rpt        = 1'b1;
                wr_en.expired   = 1'b1;
                wr_data.expired = 1'b1;
                st_nxt          = ST_EXPIRY;
                if (is_last) state_nxt = S_STATUS;
                else         idx_nxt   = idx_r + IW'(1);
              end
            end else if (is_last) begin
              state_nxt = S_STATUS;
            end else begin
              idx_nxt = idx_r + IW'(1);
            end
          end
          default: state_nxt = S_STATUS;
        endcase
      end
      S_STATUS: begin
        idx_nxt = '0;
        if (out_free) begin
          load_sts  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      count_r <= '0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      st_r    <= st_nxt;
    end
  end

  // Capture the request word on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r      <= in_word.req_type;
      key_r      <= in_word.task_key;
      deadline_r <= in_word.limit_ms;
      now_r      <= in_word.now_ms;
    end
  end

  // Output register: load a report or the status, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_rpt || load_sts) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rpt) begin
      out_word_r.event_kind <= EV_EXPIRY;
      out_word_r.report_key <= rd_data.key;
      out_word_r.status     <= ST_EXPIRY;
      out_word_r.last       <= 1'b0;
    end else if (load_sts) begin
      out_word_r.event_kind <= EV_STATUS;
      out_word_r.report_key <= '0;
      out_word_r.status     <= st_r;
      out_word_r.last       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load_sts |=> (state_r == S_IDLE) && out_valid_r && out_word_r.last)
    else $error("status word did not end the request");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en != '0) |-> (state_r == S_SCAN))
    else $error("table write outside the walk");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (load_rpt || load_sts) |-> out_free)
    else $error("result word loaded over a pending word");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_deadline_health_monitor_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_deadline_health_monitor_table_core
// Self-checking bench for the task watchdog table. A directed table covers
// empty-table requests, zero deadlines, the unused request type, known-key
// updates, deadline-equal ages, repeat expiries, time wrap and a full table.
// Random register/touch/poll traffic on a moving millisecond clock follows.
// Each result word is checked against a fixed status or an in-bench copy of the table.
// ----------------------------------------------------------------------------
module tb_deadline_health_monitor_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dhmt_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 100;
  localparam int TAIL_CYCLES    = 2 * DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    in_word_t   word;
    logic       fixed;
    logic [1:0] fixed_status;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int errors         = 0;

  // Shadow copy of the task table
  logic [31:0] watch_key      [DEPTH];
  logic [31:0] watch_deadline [DEPTH];
  logic [31:0] watch_touch    [DEPTH];
  logic        watch_expired  [DEPTH];
  int          watch_count = 0;

  out_word_t   predicted[$];
  out_word_t   pending_events[$];
  logic [31:0] clock_ms;

  deadline_health_monitor_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // Return the lowest index holding key, or DEPTH when absent
  function automatic int find_watch(logic [31:0] key);
    for (int i = 0; i < watch_count; i++) begin
      if (watch_key[i] == key) return i;
    end
    return DEPTH;
  endfunction

  function automatic void push_event(logic kind, logic [31:0] key, logic [1:0] st,
                                     logic fin);
    out_word_t ev;
    ev.event_kind = kind;
    ev.report_key = key;
    ev.status     = st;
    ev.last       = fin;
    predicted.push_back(ev);
  endfunction

  // Update the shadow table for one request and queue the words it yields
  function automatic void predict_request(in_word_t w);
    int          idx;
    logic [1:0]  st;
    logic [31:0] age;
    st = ST_OK;
    case (w.req_type)
      REQ_REGISTER: begin
        if (w.limit_ms == 32'd0) begin
          st = ST_ZERO_DEADLINE;
        end else begin
          idx = find_watch(w.task_key);
          if (idx < DEPTH) begin
            watch_deadline[idx] = w.limit_ms;
          end else if (watch_count < DEPTH) begin
            watch_key[watch_count]      = w.task_key;
            watch_deadline[watch_count] = w.limit_ms;
            watch_touch[watch_count]    = w.now_ms;
            watch_expired[watch_count]  = 1'b0;
            watch_count++;
          end else begin
            st = ST_FULL;
          end
        end
      end
      REQ_TOUCH: begin
        idx = find_watch(w.task_key);
        if (idx < DEPTH) begin
          watch_touch[idx]   = w.now_ms;
          watch_expired[idx] = 1'b0;
        end
      end
      REQ_POLL: begin
        for (int i = 0; i < watch_count; i++) begin
          age = w.now_ms - watch_touch[i];
          if (!watch_expired[i] && age > watch_deadline[i]) begin
            watch_expired[i] = 1'b1;
            push_event(EV_EXPIRY, watch_key[i], ST_EXPIRY, 1'b0);
            st = ST_EXPIRY;
          end
        end
      end
      default: ;
    endcase
    push_event(EV_STATUS, 32'd0, st, 1'b1);
  endfunction

  function automatic stim_row_t make_row(logic [1:0] req, logic [31:0] key,
                                         logic [31:0] dl, logic [31:0] now,
                                         logic fixed, logic [1:0] st);
    stim_row_t r;
    r.word.req_type = req;
    r.word.task_key = key;
    r.word.limit_ms = dl;
    r.word.now_ms   = now;
    r.fixed         = fixed;
    r.fixed_status  = st;
    return r;
  endfunction

  // Draw one request on the moving clock; flag whether the block acts on it
  function automatic in_word_t random_request(output bit useful);
    in_word_t w;
    int       pick;
    if ($urandom_range(19) == 0) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(120);
    end
    w.req_type = REQ_POLL;
    w.task_key = $urandom;
    w.limit_ms = $urandom;
    w.now_ms   = clock_ms;
    useful     = 1'b1;
    pick       = $urandom_range(99);
    if (pick < 35) begin
      w.req_type = REQ_TOUCH;
      if (watch_count > 0) w.task_key = watch_key[$urandom_range(watch_count - 1)];
      useful = (find_watch(w.task_key) < DEPTH);
    end else if (pick < 65) begin
      w.req_type = REQ_POLL;
    end else if (pick < 85) begin
      w.req_type = REQ_REGISTER;
      if (watch_count > 0) w.task_key = watch_key[$urandom_range(watch_count - 1)];
      case ($urandom_range(19))
        0:       w.limit_ms = 32'd0;
        1:       w.limit_ms = $urandom;
        2:       w.limit_ms = 32'hFFFF_FFFF;
        default: w.limit_ms = $urandom_range(400, 1);
      endcase
      useful = (w.limit_ms != 32'd0);
    end else if (pick < 93) begin
      // fresh key: appended while room remains, else dropped as full
      w.req_type = REQ_REGISTER;
      w.limit_ms = $urandom_range(400, 1);
      useful     = (watch_count < DEPTH);
    end else if (pick < 97) begin
      w.req_type = REQ_TOUCH;
      useful     = (find_watch(w.task_key) < DEPTH);
    end else begin
      w.req_type = REQ_SPARE;
      useful     = 1'b0;
    end
    return w;
  endfunction

  // Hold the word until accepted, then queue its expected results
  task automatic send_request(input in_word_t w, input logic fixed,
                              input logic [1:0] fixed_st);
    out_word_t ev;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(w);
    if (fixed) begin
      predicted.delete();
      ev.event_kind = EV_STATUS;
      ev.report_key = 32'd0;
      ev.status     = fixed_st;
      ev.last       = 1'b1;
      pending_events.push_back(ev);
    end else begin
      while (predicted.size() != 0) pending_events.push_back(predicted.pop_front());
    end
  endtask

  function automatic void check_event(out_word_t got);
    out_word_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected word kind=%0d key=%h status=%0d last=%0d",
               $time, got.event_kind, got.report_key, got.status, got.last);
      errors++;
      return;
    end
    want = pending_events.pop_front();
    if (got.event_kind !== want.event_kind || got.report_key !== want.report_key ||
        got.status !== want.status || got.last !== want.last) begin
      $display("%0t: mismatch expected kind=%0d key=%h status=%0d last=%0d",
               $time, want.event_kind, want.report_key, want.status, want.last);
      $display("%0t:          actual   kind=%0d key=%h status=%0d last=%0d",
               $time, got.event_kind, got.report_key, got.status, got.last);
      errors++;
    end
  endfunction

  // Stall the result port at random and check each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) check_event(out_word);
    end
  end

  // End the run when no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows[$];
    in_word_t  w;
    bit        useful;
    int        done_items;

    // empty table, unknown key, rejected deadline, unused request type
    rows.push_back(make_row(REQ_POLL, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK));
    rows.push_back(make_row(REQ_TOUCH, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1, ST_OK));
    rows.push_back(make_row(REQ_REGISTER, 32'd0, 32'd0, 32'd0, 1'b1, ST_ZERO_DEADLINE));
    rows.push_back(make_row(REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                            ST_OK));
    // extreme keys, deadlines and stamps
    rows.push_back(make_row(REQ_REGISTER, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_OK));
    rows.push_back(make_row(REQ_REGISTER, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b1,
                            ST_OK));
    rows.push_back(make_row(REQ_REGISTER, 32'hA5A5_A5A5, 32'd10, 32'd100, 1'b1, ST_OK));
    // known key: zero deadline leaves it alone, a new deadline keeps the stamp
    rows.push_back(make_row(REQ_REGISTER, 32'hA5A5_A5A5, 32'd0, 32'd200, 1'b1,
                            ST_ZERO_DEADLINE));
    rows.push_back(make_row(REQ_REGISTER, 32'hA5A5_A5A5, 32'd20, 32'd500, 1'b1, ST_OK));
    // age equal to deadline, then one past it; expired entries stay quiet
    rows.push_back(make_row(REQ_POLL, 32'd0, 32'd0, 32'd120, 1'b0, ST_OK));
    rows.push_back(make_row(REQ_POLL, 32'd0, 32'd0, 32'd121, 1'b0, ST_OK));
    rows.push_back(make_row(REQ_TOUCH, 32'hFFFF_FFFF, 32'd0, 32'd121, 1'b1, ST_OK));
    // time wraps past zero
    rows.push_back(make_row(REQ_POLL, 32'd0, 32'd0, 32'd0, 1'b0, ST_OK));
    // fill the table, then overflow it
    for (int i = 0; i < DEPTH - 3; i++) begin
      rows.push_back(make_row(REQ_REGISTER, 32'h0100_0000 * i + 32'h55, 40 * (i + 1),
                              1000 + 7 * i, 1'b0, ST_OK));
    end
    rows.push_back(make_row(REQ_REGISTER, 32'h5A5A_5A5A, 32'd7, 32'd3000, 1'b1, ST_FULL));
    rows.push_back(make_row(REQ_POLL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                            ST_OK));

    clock_ms = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 8;
    recv_stall_pct = 46;
    foreach (rows[i]) send_request(rows[i].word, rows[i].fixed, rows[i].fixed_status);

    // Random traffic in three idling phases
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items < RANDOM_ITEMS / 3) begin
        send_gap_pct   = 8;
        recv_stall_pct = 46;
      end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct   = 46;
        recv_stall_pct = 8;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      w = random_request(useful);
      send_request(w, 1'b0, ST_OK);
      if (useful) done_items++;
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray words
    while (pending_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dhmt_pkg.sv
hw/rtl/dhmt_table.sv
hw/rtl/dhmt_eval.sv
hw/rtl/deadline_health_monitor_table_core.sv
tb/sv/tb_deadline_health_monitor_table_core.sv
